>>> src/lps_pkg.sv
`default_nettype none

package lps_pkg;

    // Fixed coordinate width of every field.
    localparam int COORD_W = 6;

    // Error term range is -63..63, held with one spare bit.
    localparam int ERR_W = COORD_W + 2;

    // Command queue between decoder and stepper.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Decoded line command.
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] major_d;
        logic [COORD_W-1:0] minor_d;
        logic               x_neg;
        logic               y_neg;
        logic               y_major;
    } cmd_t;

    // Queue status seen by the stepper.
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

>>> src/line_pixel_stepper_top.sv
// Flow: a command is written into the queue, then loaded into the stepper registers, and its
// first pixel then goes to the output register. A line of N pixels (N = max(|dx|,|dy|)+1) takes
// a load step and then one pixel per cycle while the output is not stalled.
// The stepper makes at most one error-term update per pixel; a two-entry queue
// lets new commands be taken while a line is still being drawn.
// Reset: rst_n is asynchronous, active low, and empties the queue and the output register.
`default_nettype none

module line_pixel_stepper_top #(
    parameter int GRID_SIZE = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18]
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pix_x[5:0], pix_y[11:6], zero fill [15:12]
    output logic [15:0]      m_axis_tdata,
    // last_pixel
    output logic             m_axis_tlast
);

    lps_pkg::cmd_t                     front_cmd;
    lps_pkg::cmd_t                     head_cmd;
    lps_pkg::q_stat_t                  q_stat;
    logic                              push;
    logic                              pop;
    logic                              busy;
    logic [lps_pkg::QCNT_W-1:0]        q_count;

    // Command decode and input handshake.
    lps_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_stat        (q_stat),
        .push          (push),
        .cmd           (front_cmd)
    );

    // Decoded command queue.
    lps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .count    (q_count)
    );

    // Pixel stepper and output register.
    lps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .q_stat        (q_stat),
        .pop           (pop),
        .busy          (busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Queue occupancy never exceeds its depth.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= lps_pkg::QCNT_W'(lps_pkg::QUEUE_DEPTH))
        else $error("command queue occupancy out of range");

    // A pixel taken in mid-line is followed at once by the next pixel.
    a_line_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside a line");

    // An idle stepper picks up a waiting command on the next cycle.
    a_load_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_stat.empty && !busy) |=> busy)
        else $error("waiting command not loaded");

    // The front never takes a transaction while the queue is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && !pop) |=> (q_count == lps_pkg::QCNT_W'(lps_pkg::QUEUE_DEPTH)))
        else $error("command queue overflow");

endmodule

`default_nettype wire

>>> src/lps_front.sv
`default_nettype none

module lps_front #(
    parameter int GRID_SIZE = 64
) (
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [23:0]                  s_axis_tdata,
    input  wire lps_pkg::q_stat_t             q_stat,
    output logic                              push,
    output lps_pkg::cmd_t                     cmd
);

    localparam logic [lps_pkg::COORD_W-1:0] MAX_COORD = lps_pkg::COORD_W'(GRID_SIZE - 1);

    logic [lps_pkg::COORD_W-1:0] x0, y0, x1, y1;
    logic [lps_pkg::COORD_W:0]   dx, dy;
    logic [lps_pkg::COORD_W-1:0] adx, ady;
    logic                        y_major;

    // Clamp coordinates to the grid.
    always_comb
    begin
        x0 = (s_axis_tdata[5:0]   > MAX_COORD) ? MAX_COORD : s_axis_tdata[5:0];
        y0 = (s_axis_tdata[11:6]  > MAX_COORD) ? MAX_COORD : s_axis_tdata[11:6];
        x1 = (s_axis_tdata[17:12] > MAX_COORD) ? MAX_COORD : s_axis_tdata[17:12];
        y1 = (s_axis_tdata[23:18] > MAX_COORD) ? MAX_COORD : s_axis_tdata[23:18];
    end

    // Deltas, magnitudes and major axis selection.
    always_comb
    begin
        dx      = {1'b0, x1} - {1'b0, x0};
        dy      = {1'b0, y1} - {1'b0, y0};
        adx     = dx[lps_pkg::COORD_W] ? lps_pkg::COORD_W'(-dx) : dx[lps_pkg::COORD_W-1:0];
        ady     = dy[lps_pkg::COORD_W] ? lps_pkg::COORD_W'(-dy) : dy[lps_pkg::COORD_W-1:0];
        y_major = (ady > adx);

        cmd.x0      = x0;
        cmd.y0      = y0;
        cmd.major_d = y_major ? ady : adx;
        cmd.minor_d = y_major ? adx : ady;
        cmd.x_neg   = dx[lps_pkg::COORD_W];
        cmd.y_neg   = dy[lps_pkg::COORD_W];
        cmd.y_major = y_major;
    end

    // A transaction is taken whenever the queue has room.
    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && !q_stat.full;

endmodule

`default_nettype wire

>>> src/lps_queue.sv
`default_nettype none

module lps_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lps_pkg::cmd_t    push_cmd,
    input  wire logic             pop,
    output lps_pkg::cmd_t         head_cmd,
    output lps_pkg::q_stat_t      q_stat,
    output logic [lps_pkg::QCNT_W-1:0] count
);

    lps_pkg::cmd_t                mem_reg [lps_pkg::QUEUE_DEPTH];
    logic [lps_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lps_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lps_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == lps_pkg::QCNT_W'(lps_pkg::QUEUE_DEPTH));
    assign head_cmd     = mem_reg[rd_ptr_reg];
    assign count        = count_reg;

    // Pointer and occupancy update.
    always_comb
    begin
        do_push     = push && !q_stat.full;
        do_pop      = pop && !q_stat.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds no control state.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> src/lps_back.sv
`default_nettype none

module lps_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lps_pkg::cmd_t        head_cmd,
    input  wire lps_pkg::q_stat_t     q_stat,
    output logic                      pop,
    output logic                      busy,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [15:0]               m_axis_tdata,
    output logic                      m_axis_tlast
);

    localparam int CW = lps_pkg::COORD_W;
    localparam int EW = lps_pkg::ERR_W;

    logic                 busy_reg, busy_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        x_reg, x_next;
    logic [CW-1:0]        y_reg, y_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        major_reg, major_next;
    logic [CW-1:0]        minor_reg, minor_next;
    logic                 x_neg_reg, x_neg_next;
    logic                 y_neg_reg, y_neg_next;
    logic                 y_major_reg, y_major_next;
    logic [CW-1:0]        pix_x_reg, pix_x_next;
    logic [CW-1:0]        pix_y_reg, pix_y_next;
    logic                 last_reg, last_next;

    logic                 slot_free;
    logic signed [EW-1:0] err_sum;
    logic                 minor_step;
    logic [CW-1:0]        x_adv, y_adv;

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign pop       = !busy_reg && !q_stat.empty;
    assign busy      = busy_reg;

    // One step of the error term along the major axis.
    always_comb
    begin
        err_sum    = err_reg + $signed({2'b00, minor_reg});
        minor_step = !err_sum[EW-1] && (err_sum != '0);
        x_adv      = x_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
        y_adv      = y_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
    end

    // Stepper control and output register.
    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        err_next       = err_reg;
        rem_next       = rem_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        x_neg_next     = x_neg_reg;
        y_neg_next     = y_neg_reg;
        y_major_next   = y_major_reg;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        last_next      = last_reg;

        if (slot_free)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                pix_x_next = x_reg;
                pix_y_next = y_reg;
                last_next  = (rem_reg == '0);
                if (rem_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    rem_next = rem_reg - 1'b1;
                    err_next = minor_step ? err_sum - $signed({2'b00, major_reg}) : err_sum;
                    if (y_major_reg)
                    begin
                        y_next = y_adv;
                        if (minor_step)
                        begin
                            x_next = x_adv;
                        end
                    end
                    else
                    begin
                        x_next = x_adv;
                        if (minor_step)
                        begin
                            y_next = y_adv;
                        end
                    end
                end
            end
        end

        // Load the next command once the current line is done.
        if (pop)
        begin
            busy_next    = 1'b1;
            x_next       = head_cmd.x0;
            y_next       = head_cmd.y0;
            err_next     = '0;
            rem_next     = head_cmd.major_d;
            major_next   = head_cmd.major_d;
            minor_next   = head_cmd.minor_d;
            x_neg_next   = head_cmd.x_neg;
            y_neg_next   = head_cmd.y_neg;
            y_major_next = head_cmd.y_major;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        err_reg     <= err_next;
        rem_reg     <= rem_next;
        major_reg   <= major_next;
        minor_reg   <= minor_next;
        x_neg_reg   <= x_neg_next;
        y_neg_reg   <= y_neg_next;
        y_major_reg <= y_major_next;
        pix_x_reg   <= pix_x_next;
        pix_y_reg   <= pix_y_next;
        last_reg    <= last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, pix_y_reg, pix_x_reg};
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int GRID       = 64;
    localparam int RAND_LINES = 450;
    localparam int CALM_LINES = 40;
    localparam int HOLD_AFTER = 80;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_AT   = 250;
    localparam int TAIL_WAIT  = 70;
    localparam int CYCLE_CAP  = 500000;
    localparam int MAX_SHOWN  = 10;

    // One emitted pixel as seen on the output stream.
    typedef struct packed {
        logic [lps_pkg::COORD_W-1:0] x;
        logic [lps_pkg::COORD_W-1:0] y;
        logic                        last;
    } pixel_t;

    // One directed line command. Rows marked fixed carry the single pixel they must produce.
    typedef struct packed {
        logic [lps_pkg::COORD_W-1:0] xs;
        logic [lps_pkg::COORD_W-1:0] ys;
        logic [lps_pkg::COORD_W-1:0] xe;
        logic [lps_pkg::COORD_W-1:0] ye;
        logic                        fixed;
        pixel_t                      fixed_px;
    } line_row_t;

    localparam int DIR_LINES = 20;
    localparam line_row_t DIR_TAB [DIR_LINES] = '{
        // Equal start and end: one pixel, marked last.
        '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, '{6'd0,  6'd0,  1'b1}},
        '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, '{6'd63, 6'd63, 1'b1}},
        '{6'd21, 6'd42, 6'd21, 6'd42, 1'b1, '{6'd21, 6'd42, 1'b1}},
        // Full-length horizontal and vertical lines in both directions.
        '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0, '0},
        '{6'd63, 6'd0,  6'd0,  6'd0,  1'b0, '0},
        '{6'd0,  6'd0,  6'd0,  6'd63, 1'b0, '0},
        '{6'd0,  6'd63, 6'd0,  6'd0,  1'b0, '0},
        // Full diagonals in all four directions.
        '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0, '0},
        '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0, '0},
        '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0, '0},
        '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0, '0},
        // Very shallow and very steep lines.
        '{6'd0,  6'd0,  6'd63, 6'd1,  1'b0, '0},
        '{6'd0,  6'd0,  6'd1,  6'd63, 1'b0, '0},
        '{6'd10, 6'd10, 6'd13, 6'd20, 1'b0, '0},
        '{6'd40, 6'd30, 6'd20, 6'd25, 1'b0, '0},
        // Two-pixel lines, then two longer diagonals.
        '{6'd5,  6'd5,  6'd6,  6'd6,  1'b0, '0},
        '{6'd5,  6'd5,  6'd6,  6'd5,  1'b0, '0},
        '{6'd5,  6'd5,  6'd5,  6'd4,  1'b0, '0},
        '{6'd42, 6'd21, 6'd21, 6'd42, 1'b0, '0},
        '{6'd1,  6'd62, 6'd62, 6'd1,  1'b0, '0}
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    pixel_t      pixel_q [$];
    int          mismatch_cnt = 0;
    int          line_cnt     = 0;
    int unsigned cycle_cnt    = 0;
    bit          calm         = 1'b0;
    bit          hold_done    = 1'b0;

    line_pixel_stepper_top #(
        .GRID_SIZE(GRID)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Steps the line exactly as the stepper should and queues every pixel it draws.
    // Coordinates are six bits wide, so saturation at the grid edge never comes into play.
    function automatic void trace_line(input logic [lps_pkg::COORD_W-1:0] xs,
                                       input logic [lps_pkg::COORD_W-1:0] ys,
                                       input logic [lps_pkg::COORD_W-1:0] xe,
                                       input logic [lps_pkg::COORD_W-1:0] ye);
        int     dx;
        int     dy;
        int     adx;
        int     ady;
        int     sx;
        int     sy;
        int     steps;
        int     x;
        int     y;
        int     acc;
        bit     y_major;
        pixel_t px;
        dx      = int'(xe) - int'(xs);
        dy      = int'(ye) - int'(ys);
        adx     = (dx < 0) ? -dx : dx;
        ady     = (dy < 0) ? -dy : dy;
        sx      = (dx > 0) ? 1 : -1;
        sy      = (dy < 0) ? -1 : 1;
        y_major = (ady > adx);
        steps   = y_major ? ady : adx;
        x       = xs;
        y       = ys;
        acc     = 0;
        px      = '{xs, ys, (steps == 0)};
        pixel_q.push_back(px);
        for (int n = 1; n <= steps; n++)
        begin
            // The minor axis advances whenever the error term turns positive.
            if (y_major)
            begin
                acc += adx;
                if (acc > 0)
                begin
                    acc -= ady;
                    x   += sx;
                end
                y += sy;
            end
            else
            begin
                acc += ady;
                if (acc > 0)
                begin
                    acc -= adx;
                    y   += sy;
                end
                x += sx;
            end
            px = '{x[lps_pkg::COORD_W-1:0], y[lps_pkg::COORD_W-1:0], (n == steps)};
            pixel_q.push_back(px);
        end
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
            $display("mismatch %0d: %s expected %0d, got %0d", mismatch_cnt, what, want, got);
    endfunction

    function automatic int pick_coord(input int base, input int delta);
        int v;
        v = base + delta;
        if (v < 0)
            v = 0;
        if (v > GRID - 1)
            v = GRID - 1;
        return v;
    endfunction

    // Offers one line command, waits for its transaction, then records what it must draw.
    task automatic send_line(input logic [lps_pkg::COORD_W-1:0] xs,
                             input logic [lps_pkg::COORD_W-1:0] ys,
                             input logic [lps_pkg::COORD_W-1:0] xe,
                             input logic [lps_pkg::COORD_W-1:0] ye,
                             input logic fixed, input pixel_t fixed_px);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ye, xe, ys, xs};
        do
            @(posedge clk);
        while (!s_axis_tready);
        line_cnt++;
        if (fixed)
            pixel_q.push_back(fixed_px);
        else
            trace_line(xs, ys, xe, ye);
    endtask

    // Drops the valid and waits until every queued pixel has come out.
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
    endtask

    // Command sender: reset, directed table, then random lines.
    initial
    begin
        int kind;
        int xs;
        int ys;
        int xe;
        int ye;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_LINES; i++)
            send_line(DIR_TAB[i].xs, DIR_TAB[i].ys, DIR_TAB[i].xe, DIR_TAB[i].ye,
                      DIR_TAB[i].fixed, DIR_TAB[i].fixed_px);
        drain_pixels();

        for (int i = 0; i < RAND_LINES; i++)
        begin
            if (i == DRAIN_AT)
                drain_pixels();
            calm = (i >= RAND_LINES - CALM_LINES);
            kind = $urandom_range(0, 19);
            xs   = $urandom_range(0, GRID - 1);
            ys   = $urandom_range(0, GRID - 1);
            if (kind < 12)
            begin
                // Anywhere on the grid.
                xe = $urandom_range(0, GRID - 1);
                ye = $urandom_range(0, GRID - 1);
            end
            else if (kind < 15)
            begin
                // Short line around the start point.
                xe = pick_coord(xs, int'($urandom_range(0, 6)) - 3);
                ye = pick_coord(ys, int'($urandom_range(0, 6)) - 3);
            end
            else if (kind < 17)
            begin
                // Axis-aligned line.
                xe = ($urandom_range(0, 1) == 0) ? xs : $urandom_range(0, GRID - 1);
                ye = (xe != xs) ? ys : $urandom_range(0, GRID - 1);
            end
            else if (kind < 19)
            begin
                // Exact diagonal, clipped at the x edge; one that would leave the grid in y becomes a single point.
                ye = int'($urandom_range(0, 40)) - 20;
                xe = pick_coord(xs, ($urandom_range(0, 1) == 0) ? ye : -ye);
                ye = ys + (((ye < 0) == (xe < xs)) ? (xe - xs) : (xs - xe));
                if (ye < 0 || ye > GRID - 1)
                begin
                    xe = xs;
                    ye = ys;
                end
            end
            else
            begin
                // Single point.
                xe = xs;
                ye = ys;
            end
            send_line(xs[lps_pkg::COORD_W-1:0], ys[lps_pkg::COORD_W-1:0],
                      xe[lps_pkg::COORD_W-1:0], ye[lps_pkg::COORD_W-1:0],
                      1'b0, '0);
        end
        drain_pixels();
        repeat (TAIL_WAIT) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Pixel receiver: random stalls, one long hold-off once HOLD_AFTER lines have been sent.
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && line_cnt >= HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each pixel transaction with the oldest queued pixel.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                note_mismatch("unexpected pixel, x", -1, m_axis_tdata[5:0]);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (m_axis_tdata[5:0] != want.x)
                    note_mismatch("pix_x", want.x, m_axis_tdata[5:0]);
                if (m_axis_tdata[11:6] != want.y)
                    note_mismatch("pix_y", want.y, m_axis_tdata[11:6]);
                if (m_axis_tlast !== want.last)
                    note_mismatch("last_pixel", want.last, m_axis_tlast);
                if (m_axis_tdata[15:12] !== 4'd0)
                    note_mismatch("zero fill", 0, m_axis_tdata[15:12]);
            end
        end
    end

endmodule

>>> files.f
src/lps_pkg.sv
src/lps_front.sv
src/lps_queue.sv
src/lps_back.sv
src/line_pixel_stepper_top.sv
tb/tb.sv
